// ===== hw/rtl/rdz_pkg.sv =====
// shared constants and types for the radial dead zone stick filter
package rdz_pkg;

    localparam int AXIS_BITS   = 16;
    localparam int REG_W       = 15;
    localparam int REG_IDX_W   = 1;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [REG_IDX_W-1:0] REG_DEAD_ZONE_RADIUS    = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_CARDINAL_HALF_WIDTH = 1'd1;

    localparam logic [REG_W-1:0] RADIUS_RESET     = 15'd4915;
    localparam logic [REG_W-1:0] HALF_WIDTH_RESET = 15'd1638;

    typedef struct packed {
        logic pass;
        logic zero;
    } rdz_flags_t;

endpackage

// ===== hw/rtl/rdz_isqrt.sv =====
// pipelined integer square root, one result bit per stage
module rdz_isqrt #(
    parameter int IW = 32,
    parameter int SW = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [IW-1:0]     rad,
    input  logic [SW-1:0]     in_side,
    output logic              out_valid,
    output logic [IW/2-1:0]   root,
    output logic [SW-1:0]     out_side
);

    localparam int OW = IW / 2;

    logic              valid_reg [OW];
    logic [SW-1:0]     side_reg  [OW];
    logic [IW-1:0]     rad_reg   [OW];
    logic [OW+1:0]     rem_reg   [OW];
    logic [OW-1:0]     root_reg  [OW];

    for (genvar s = 0; s < OW; s++) begin : g_stage
        logic              v_p;
        logic [SW-1:0]     side_p;
        logic [IW-1:0]     rad_p;
        logic [OW+1:0]     rem_p;
        logic [OW-1:0]     root_p;
        logic [OW+1:0]     t;
        logic [OW+1:0]     trial;
        logic              ge;

        if (s == 0) begin : g_src_first
            assign v_p    = in_valid;
            assign side_p = in_side;
            assign rad_p  = rad;
            assign rem_p  = '0;
            assign root_p = '0;
        end else begin : g_src_prev
            assign v_p    = valid_reg[s-1];
            assign side_p = side_reg[s-1];
            assign rad_p  = rad_reg[s-1];
            assign rem_p  = rem_reg[s-1];
            assign root_p = root_reg[s-1];
        end

        assign t     = {rem_p[OW-1:0], rad_p[IW-1:IW-2]};
        assign trial = {root_p, 2'b01};
        assign ge    = t >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= v_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[s] <= side_p;
                rad_reg[s]  <= {rad_p[IW-3:0], 2'b00};
                rem_reg[s]  <= ge ? (t - trial) : t;
                root_reg[s] <= {root_p[OW-2:0], ge};
            end
        end
    end

    assign out_valid = valid_reg[OW-1];
    assign out_side  = side_reg[OW-1];
    assign root      = root_reg[OW-1];

endmodule

// ===== hw/rtl/rdz_div.sv =====
// pipelined restoring divider, several lanes in lock step, one quotient bit per stage
module rdz_div #(
    parameter int LANES = 1,
    parameter int NW    = 32,
    parameter int DW    = 16,
    parameter int QW    = 16,
    parameter int SW    = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [LANES*NW-1:0]   num,
    input  logic [LANES*DW-1:0]   den,
    input  logic [SW-1:0]         in_side,
    output logic                  out_valid,
    output logic [LANES*QW-1:0]   quo,
    output logic [SW-1:0]         out_side
);

    logic              valid_reg [QW];
    logic [SW-1:0]     side_reg  [QW];
    logic [DW-1:0]     rem_reg   [QW][LANES];
    logic [DW-1:0]     den_reg   [QW][LANES];
    logic [QW-1:0]     low_reg   [QW][LANES];
    logic [QW-1:0]     q_reg     [QW][LANES];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic          v_p;
        logic [SW-1:0] side_p;

        if (s == 0) begin : g_vsrc_first
            assign v_p    = in_valid;
            assign side_p = in_side;
        end else begin : g_vsrc_prev
            assign v_p    = valid_reg[s-1];
            assign side_p = side_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= v_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[s] <= side_p;
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [NW+DW-1:0] wide;
            logic [DW-1:0]    rem_p;
            logic [DW-1:0]    den_p;
            logic [QW-1:0]    low_p;
            logic [QW-1:0]    q_p;
            logic [DW:0]      t;
            logic [DW:0]      diff;
            logic             ge;

            if (s == 0) begin : g_src_first
                assign wide  = {{DW{1'b0}}, num[l*NW +: NW]} >> QW;
                assign rem_p = wide[DW-1:0];
                assign den_p = den[l*DW +: DW];
                assign low_p = num[l*NW +: QW];
                assign q_p   = '0;
            end else begin : g_src_prev
                assign wide  = '0;
                assign rem_p = rem_reg[s-1][l];
                assign den_p = den_reg[s-1][l];
                assign low_p = low_reg[s-1][l];
                assign q_p   = q_reg[s-1][l];
            end

            assign t    = {rem_p, low_p[QW-1]};
            assign diff = t - {1'b0, den_p};
            assign ge   = t >= {1'b0, den_p};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s][l] <= ge ? diff[DW-1:0] : t[DW-1:0];
                    den_reg[s][l] <= den_p;
                    low_reg[s][l] <= {low_p[QW-2:0], 1'b0};
                    q_reg[s][l]   <= {q_p[QW-2:0], ge};
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            quo[l*QW +: QW] = q_reg[QW-1][l];
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

// ===== hw/rtl/rdz_queue.sv =====
// short fifo between the classify front end and the scaling back end
module rdz_queue #(
    parameter int W = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [W-1:0]  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [W-1:0]  out_data
);

    localparam int DEPTH = rdz_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_reg;
    logic [AW-1:0] rd_reg;
    logic [AW:0]   count_reg;
    logic          push;
    logic          pop;

    assign in_ready  = count_reg != (AW+1)'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_data;
        end
    end

endmodule

// ===== hw/rtl/rdz_front.sv =====
// front end: magnitude, dead zone classification, per-axis dead band and radial size
module rdz_front #(
    parameter int AB = rdz_pkg::AXIS_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [AB-1:0]            in_x,
    input  logic [AB-1:0]            in_y,
    input  logic [rdz_pkg::REG_W-1:0] radius,
    input  logic [rdz_pkg::REG_W-1:0] half_width,
    output logic                     out_valid,
    input  logic                     out_ready,
    output rdz_pkg::rdz_flags_t      out_flags,
    output logic [AB-1:0]            out_x,
    output logic [AB-1:0]            out_y,
    output logic [AB-1:0]            out_cx,
    output logic                     out_cx_neg,
    output logic [AB-1:0]            out_cy,
    output logic                     out_cy_neg,
    output logic [2*AB-2:0]          out_size
);

    localparam int F   = AB - 1;
    localparam int RW  = rdz_pkg::REG_W;
    localparam int NZ  = (2 ** F) / 10000;
    localparam int SW1 = 4 * AB + 2 * F + 2;
    localparam int SW2 = 2 * AB + 4;
    localparam int NW  = AB + F;

    logic en;

    logic [AB-1:0]     ax_in;
    logic [AB-1:0]     ay_in;
    logic [2*AB-1:0]   sqx_full;
    logic [2*AB-1:0]   sqy_full;
    logic [RW+F-1:0]   r_wide;
    logic [RW+F-1:0]   c_wide;
    logic [F-1:0]      r_in;
    logic [F-1:0]      c_raw;
    logic [F-1:0]      c_in;

    logic              v0_reg;
    logic [AB-1:0]     x0_reg;
    logic [AB-1:0]     y0_reg;
    logic [AB-1:0]     ax0_reg;
    logic [AB-1:0]     ay0_reg;
    logic [2*AB-2:0]   sqx0_reg;
    logic [2*AB-2:0]   sqy0_reg;
    logic [F-1:0]      r0_reg;
    logic [F-1:0]      c0_reg;
    logic              pass0_reg;
    logic              near0_reg;

    logic [2*AB-1:0]   rad;
    logic [SW1-1:0]    side1_in;
    logic [SW1-1:0]    side1;
    logic              v1;
    logic [AB-1:0]     mag1;
    logic [AB-1:0]     x1;
    logic [AB-1:0]     y1;
    logic [AB-1:0]     ax1;
    logic [AB-1:0]     ay1;
    logic [F-1:0]      r1;
    logic [F-1:0]      c1;
    logic              pass1;
    logic              near1;

    logic [AB-1:0]     fs;
    logic [AB-1:0]     c1_ext;
    logic [AB-1:0]     r1_ext;
    logic              below1;
    logic              dbz1;
    logic [AB-1:0]     diffx;
    logic [AB-1:0]     diffy;
    logic [AB-1:0]     dmag;
    logic [NW-1:0]     numx;
    logic [NW-1:0]     numy;
    logic [NW-1:0]     nums;
    logic [AB-1:0]     denc;
    logic [AB-1:0]     denr;
    rdz_pkg::rdz_flags_t flags1;
    logic [SW2-1:0]    side2;
    logic [3*NW-1:0]   quo;

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    assign ax_in    = in_x[AB-1] ? (~in_x + 1'b1) : in_x;
    assign ay_in    = in_y[AB-1] ? (~in_y + 1'b1) : in_y;
    assign sqx_full = ax_in * ax_in;
    assign sqy_full = ay_in * ay_in;
    assign r_wide   = {radius, {F{1'b0}}};
    assign c_wide   = {half_width, {F{1'b0}}};
    assign r_in     = r_wide[RW+F-1:RW];
    assign c_raw    = c_wide[RW+F-1:RW];
    assign c_in     = (c_raw > r_in) ? r_in : c_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg    <= in_x;
            y0_reg    <= in_y;
            ax0_reg   <= ax_in;
            ay0_reg   <= ay_in;
            sqx0_reg  <= sqx_full[2*AB-2:0];
            sqy0_reg  <= sqy_full[2*AB-2:0];
            r0_reg    <= r_in;
            c0_reg    <= c_in;
            pass0_reg <= r_in == '0;
            near0_reg <= (ax_in <= AB'(NZ)) && (ay_in <= AB'(NZ));
        end
    end

    assign rad      = {1'b0, sqx0_reg} + {1'b0, sqy0_reg};
    assign side1_in = {x0_reg, y0_reg, ax0_reg, ay0_reg, r0_reg, c0_reg, pass0_reg, near0_reg};

    rdz_isqrt #(
        .IW (2 * AB),
        .SW (SW1)
    ) u_mag_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v0_reg),
        .rad       (rad),
        .in_side   (side1_in),
        .out_valid (v1),
        .root      (mag1),
        .out_side  (side1)
    );

    assign {x1, y1, ax1, ay1, r1, c1, pass1, near1} = side1;

    // a near-zero sample, a magnitude below the radius or both axes inside the band give zero
    assign fs     = {1'b1, {F{1'b0}}};
    assign c1_ext = {1'b0, c1};
    assign r1_ext = {1'b0, r1};
    assign below1 = mag1 < r1_ext;
    assign dbz1   = (ax1 <= c1_ext) && (ay1 <= c1_ext);
    assign diffx  = ax1 - c1_ext;
    assign diffy  = ay1 - c1_ext;
    assign dmag   = mag1 - r1_ext;
    assign numx   = (ax1 > c1_ext) ? {diffx, {F{1'b0}}} : '0;
    assign numy   = (ay1 > c1_ext) ? {diffy, {F{1'b0}}} : '0;
    assign nums   = below1 ? '0 : {dmag, {F{1'b0}}};
    assign denc   = fs - c1_ext;
    assign denr   = fs - r1_ext;

    assign flags1.pass = pass1;
    assign flags1.zero = near1 || below1 || dbz1;
    assign side2       = {x1, y1, flags1, x1[AB-1], y1[AB-1]};

    // the radial size can reach far beyond full scale for a large radius
    rdz_div #(
        .LANES (3),
        .NW    (NW),
        .DW    (AB),
        .QW    (NW),
        .SW    (SW2)
    ) u_band_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1),
        .num       ({nums, numy, numx}),
        .den       ({denr, denc, denc}),
        .in_side   (side2),
        .out_valid (out_valid),
        .quo       (quo),
        .out_side  ({out_x, out_y, out_flags, out_cx_neg, out_cy_neg})
    );

    assign out_cx   = quo[AB-1:0];
    assign out_cy   = quo[NW +: AB];
    assign out_size = quo[2*NW +: NW];

endmodule

// ===== hw/rtl/rdz_back.sv =====
// back end: vector length, direction and final scaling with saturation, or pass-through or zero by flag
module rdz_back #(
    parameter int AB = rdz_pkg::AXIS_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rdz_pkg::rdz_flags_t in_flags,
    input  logic [AB-1:0]       in_x,
    input  logic [AB-1:0]       in_y,
    input  logic [AB-1:0]       in_cx,
    input  logic                in_cx_neg,
    input  logic [AB-1:0]       in_cy,
    input  logic                in_cy_neg,
    input  logic [2*AB-2:0]     in_size,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [AB-1:0]       out_x,
    output logic [AB-1:0]       out_y
);

    localparam int F   = AB - 1;
    localparam int ZW  = 2 * AB - 1;
    localparam int LW  = AB + 8;
    localparam int DQ  = AB + 2;
    localparam int PW  = DQ + ZW;
    localparam int MW  = PW - F - 2;
    localparam int SW1 = 4 * AB + 4 + ZW;
    localparam int SW2 = 2 * AB + 4 + ZW;

    logic en;

    logic [2*AB-1:0]   sqx_full;
    logic [2*AB-1:0]   sqy_full;

    logic              v0_reg;
    logic [2*AB-2:0]   sqx0_reg;
    logic [2*AB-2:0]   sqy0_reg;
    logic [AB-1:0]     cx0_reg;
    logic [AB-1:0]     cy0_reg;
    logic              sx0_reg;
    logic              sy0_reg;
    logic [ZW-1:0]     size0_reg;
    rdz_pkg::rdz_flags_t flags0_reg;
    logic [AB-1:0]     x0_reg;
    logic [AB-1:0]     y0_reg;

    logic [2*AB+15:0]  rad;
    logic [SW1-1:0]    side1;
    logic              v1;
    logic [LW-1:0]     l8;
    logic [AB-1:0]     cx1;
    logic [AB-1:0]     cy1;
    logic              sx1;
    logic              sy1;
    logic [ZW-1:0]     size1;
    rdz_pkg::rdz_flags_t flags1;
    logic [AB-1:0]     x1;
    logic [AB-1:0]     y1;

    logic              v2;
    logic [2*DQ-1:0]   dir;
    logic [SW2-1:0]    side2;
    logic              sx2;
    logic              sy2;
    logic [ZW-1:0]     size2;
    rdz_pkg::rdz_flags_t flags2;
    logic [AB-1:0]     x2;
    logic [AB-1:0]     y2;
    logic [PW-1:0]     px_full;
    logic [PW-1:0]     py_full;

    logic              v3_reg;
    logic [PW-1:0]     px3_reg;
    logic [PW-1:0]     py3_reg;
    logic              sx3_reg;
    logic              sy3_reg;
    rdz_pkg::rdz_flags_t flags3_reg;
    logic [AB-1:0]     x3_reg;
    logic [AB-1:0]     y3_reg;

    logic              out_valid_reg;
    logic [AB-1:0]     out_x_reg;
    logic [AB-1:0]     out_y_reg;

    // drop the direction fraction, clamp to the axis range and apply the sign
    function automatic logic [AB-1:0] shape(input logic [PW-1:0] p, input logic neg);
        logic [MW-1:0] m;
        logic          sat;
        begin
            m   = p[PW-1:F+2];
            sat = |m[MW-1:AB-1];
            if (neg)
            begin
                shape = sat ? {1'b1, {F{1'b0}}} : (~m[AB-1:0] + 1'b1);
            end
            else
            begin
                shape = sat ? {1'b0, {F{1'b1}}} : m[AB-1:0];
            end
        end
    endfunction

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;
    assign sqx_full = in_cx * in_cx;
    assign sqy_full = in_cy * in_cy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg        <= in_valid;
            v3_reg        <= v2;
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx0_reg   <= sqx_full[2*AB-2:0];
            sqy0_reg   <= sqy_full[2*AB-2:0];
            cx0_reg    <= in_cx;
            cy0_reg    <= in_cy;
            sx0_reg    <= in_cx_neg;
            sy0_reg    <= in_cy_neg;
            size0_reg  <= in_size;
            flags0_reg <= in_flags;
            x0_reg     <= in_x;
            y0_reg     <= in_y;
        end
    end

    assign rad = {({1'b0, sqx0_reg} + {1'b0, sqy0_reg}), 16'b0};

    rdz_isqrt #(
        .IW (2 * AB + 16),
        .SW (SW1)
    ) u_len_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v0_reg),
        .rad       (rad),
        .in_side   ({cx0_reg, cy0_reg, sx0_reg, sy0_reg, size0_reg, flags0_reg,
                     x0_reg, y0_reg}),
        .out_valid (v1),
        .root      (l8),
        .out_side  (side1)
    );

    assign {cx1, cy1, sx1, sy1, size1, flags1, x1, y1} = side1;

    rdz_div #(
        .LANES (2),
        .NW    (AB + F + 10),
        .DW    (LW),
        .QW    (DQ),
        .SW    (SW2)
    ) u_dir_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1),
        .num       ({cy1, {(F+10){1'b0}}, cx1, {(F+10){1'b0}}}),
        .den       ({l8, l8}),
        .in_side   ({sx1, sy1, size1, flags1, x1, y1}),
        .out_valid (v2),
        .quo       (dir),
        .out_side  (side2)
    );

    assign {sx2, sy2, size2, flags2, x2, y2} = side2;
    assign px_full = dir[DQ-1:0] * size2;
    assign py_full = dir[2*DQ-1:DQ] * size2;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px3_reg    <= px_full;
            py3_reg    <= py_full;
            sx3_reg    <= sx2;
            sy3_reg    <= sy2;
            flags3_reg <= flags2;
            x3_reg     <= x2;
            y3_reg     <= y2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (flags3_reg.pass)
            begin
                out_x_reg <= x3_reg;
                out_y_reg <= y3_reg;
            end
            else if (flags3_reg.zero)
            begin
                out_x_reg <= '0;
                out_y_reg <= '0;
            end
            else
            begin
                out_x_reg <= shape(px3_reg, sx3_reg);
                out_y_reg <= shape(py3_reg, sy3_reg);
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;

endmodule

// ===== hw/rtl/radial_dead_zone_stick_filter.sv =====
// top level of the radial dead zone stick filter
//
// s_* carries one stick sample per transaction, m_* one filtered sample.
// cfg_we/cfg_index/cfg_data write the radius (index 0) and the cardinal
// half width (index 1), both Q0.15; write them only while the block is idle.
// One sample is accepted per cycle while s_tready is high; the two
// square-root pipelines and the divider pipelines each resolve one bit
// per stage, which sets the latency.
// The front end and the back end stall independently; a four-entry queue
// sits between them, so s_tready stays high while the output is stalled
// until the queue has filled and the front end holds a valid result.
// Reset empties all pipelines and the queue and loads the radius with
// 4915 (0.15) and the half width with 1638 (0.05).
// A held m_tvalid keeps m_tdata until the transaction completes.
module radial_dead_zone_stick_filter #(
    parameter int AXIS_BITS = rdz_pkg::AXIS_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rdz_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [rdz_pkg::REG_W-1:0]         cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // stick_x, stick_y
    input  logic [((2*AXIS_BITS+7)/8)*8-1:0]  s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // filtered_x, filtered_y
    output logic [((2*AXIS_BITS+7)/8)*8-1:0]  m_tdata
);

    localparam int AB = AXIS_BITS;
    localparam int TW = ((2 * AB + 7) / 8) * 8;
    localparam int QW = 4 * AB + 4 + (2 * AB - 1);

    logic [rdz_pkg::REG_W-1:0] radius_reg;
    logic [rdz_pkg::REG_W-1:0] half_width_reg;

    logic                f_valid;
    rdz_pkg::rdz_flags_t f_flags;
    logic [AB-1:0]       f_x;
    logic [AB-1:0]       f_y;
    logic [AB-1:0]       f_cx;
    logic                f_cx_neg;
    logic [AB-1:0]       f_cy;
    logic                f_cy_neg;
    logic [2*AB-2:0]     f_size;

    logic                q_in_ready;
    logic                q_out_valid;
    logic [QW-1:0]       q_out_data;
    logic                b_in_ready;
    rdz_pkg::rdz_flags_t b_flags;
    logic [AB-1:0]       b_x;
    logic [AB-1:0]       b_y;
    logic [AB-1:0]       b_cx;
    logic                b_cx_neg;
    logic [AB-1:0]       b_cy;
    logic                b_cy_neg;
    logic [2*AB-2:0]     b_size;
    logic [AB-1:0]       out_x;
    logic [AB-1:0]       out_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg     <= rdz_pkg::RADIUS_RESET;
            half_width_reg <= rdz_pkg::HALF_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rdz_pkg::REG_DEAD_ZONE_RADIUS:    radius_reg     <= cfg_data;
                rdz_pkg::REG_CARDINAL_HALF_WIDTH: half_width_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    rdz_front #(
        .AB (AB)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_x       (s_tdata[AB-1:0]),
        .in_y       (s_tdata[2*AB-1:AB]),
        .radius     (radius_reg),
        .half_width (half_width_reg),
        .out_valid  (f_valid),
        .out_ready  (q_in_ready),
        .out_flags  (f_flags),
        .out_x      (f_x),
        .out_y      (f_y),
        .out_cx     (f_cx),
        .out_cx_neg (f_cx_neg),
        .out_cy     (f_cy),
        .out_cy_neg (f_cy_neg),
        .out_size   (f_size)
    );

    rdz_queue #(
        .W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (q_in_ready),
        .in_data   ({f_flags, f_x, f_y, f_cx, f_cx_neg, f_cy, f_cy_neg, f_size}),
        .out_valid (q_out_valid),
        .out_ready (b_in_ready),
        .out_data  (q_out_data)
    );

    assign {b_flags, b_x, b_y, b_cx, b_cx_neg, b_cy, b_cy_neg, b_size} = q_out_data;

    rdz_back #(
        .AB (AB)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_out_valid),
        .in_ready  (b_in_ready),
        .in_flags  (b_flags),
        .in_x      (b_x),
        .in_y      (b_y),
        .in_cx     (b_cx),
        .in_cx_neg (b_cx_neg),
        .in_cy     (b_cy),
        .in_cy_neg (b_cy_neg),
        .in_size   (b_size),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_x     (out_x),
        .out_y     (out_y)
    );

    assign m_tdata = TW'({out_y, out_x});

`ifndef NO_ASSERTIONS
    a_front_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (f_valid && !q_in_ready) |=> f_valid)
        else $error("front end lost a transaction while the queue was full");

    a_ready_only_when_backed_up: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (f_valid && !q_in_ready))
        else $error("input stalled without a full queue");

    a_radius_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == rdz_pkg::REG_DEAD_ZONE_RADIUS) |=>
        (radius_reg == $past(cfg_data)))
        else $error("radius register missed a write");
`endif

endmodule

// ===== bench/rdz_checker.sv =====
// result checker for the radial dead zone stick filter: predicts each filtered sample
`timescale 1ns / 1ps
module rdz_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rdz_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [rdz_pkg::REG_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [31:0]                   s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [31:0]                   m_tdata,
    output int                            fail_count,
    output int                            pending_count
);
    import rdz_pkg::*;

    localparam int FRAC = AXIS_BITS - 1;
    localparam longint FSV = longint'(1) << FRAC;
    localparam longint NEAR = FSV / 10000;
    localparam int DIRF = FRAC + 2;

    logic [REG_W-1:0] radius_reg;
    logic [REG_W-1:0] half_width_reg;
    logic [31:0] expected_samples[$];

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint band_axis(input longint v, input longint c);
        longint a;
        longint m;
        a = v < 0 ? -v : v;
        if (a < c) return 0;
        m = ((a - c) * FSV) / (FSV - c);
        return v < 0 ? -m : m;
    endfunction

    function automatic longint steer_axis(input longint cv, input longint unsigned l8,
                                          input longint unsigned size);
        longint unsigned a;
        longint unsigned dir;
        longint unsigned lim;
        longint unsigned mag;
        bit sat;
        a = cv < 0 ? -cv : cv;
        sat = 0;
        mag = 0;
        if (a == 0) return 0;
        dir = (a << (DIRF + 8)) / l8;
        if (dir == 0) return 0;
        lim = (longint'(FSV) << DIRF) / dir;
        if (size > lim) sat = 1;
        else mag = (dir * size) >> DIRF;
        if (cv > 0)
        begin
            if (sat || mag > FSV - 1) return FSV - 1;
            return longint'(mag);
        end
        if (sat || mag > FSV) return -FSV;
        return -longint'(mag);
    endfunction

    function automatic logic [31:0] filter_sample(input logic [31:0] raw);
        longint x;
        longint y;
        longint r;
        longint c;
        longint mag;
        longint cx;
        longint cy;
        longint fx;
        longint fy;
        longint unsigned l8;
        longint unsigned size;
        x = longint'($signed(raw[15:0]));
        y = longint'($signed(raw[31:16]));
        r = (longint'(radius_reg) << FRAC) >> 15;
        c = (longint'(half_width_reg) << FRAC) >> 15;
        if (c > r) c = r;
        if (r == 0) return raw;
        if ((x < 0 ? -x : x) <= NEAR && (y < 0 ? -y : y) <= NEAR) return 32'd0;
        mag = longint'(int_sqrt(x * x + y * y));
        if (mag < r) return 32'd0;
        cx = band_axis(x, c);
        cy = band_axis(y, c);
        if (cx == 0 && cy == 0) return 32'd0;
        l8 = int_sqrt((cx * cx + cy * cy) << 16);
        size = ((mag - r) * FSV) / (FSV - r);
        fx = steer_axis(cx, l8, size);
        fy = steer_axis(cy, l8, size);
        return {fy[15:0], fx[15:0]};
    endfunction

    assign pending_count = expected_samples.size();

    always @(posedge clk or negedge rst_n)
    begin
        int errs;
        errs = 0;
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            half_width_reg <= HALF_WIDTH_RESET;
            fail_count <= 0;
            expected_samples.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_samples.push_back(filter_sample(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (expected_samples.size() == 0)
                begin
                    $error("unexpected transaction %h", m_tdata);
                    errs++;
                end
                else
                begin
                    logic [31:0] want;
                    want = expected_samples.pop_front();
                    if (want[15:0] !== m_tdata[15:0])
                    begin
                        $error("filtered_x expected %0d actual %0d",
                               $signed(want[15:0]), $signed(m_tdata[15:0]));
                        errs++;
                    end
                    if (want[31:16] !== m_tdata[31:16])
                    begin
                        $error("filtered_y expected %0d actual %0d",
                               $signed(want[31:16]), $signed(m_tdata[31:16]));
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
            if (cfg_we)
            begin
                if (cfg_index == REG_DEAD_ZONE_RADIUS) radius_reg <= cfg_data;
                else if (cfg_index == REG_CARDINAL_HALF_WIDTH) half_width_reg <= cfg_data;
            end
        end
    end
endmodule

// ===== bench/tb_top.sv =====
// testbench top for the radial dead zone stick filter: stimulus and verdict
`timescale 1ns / 1ps
module tb_top;
    import rdz_pkg::*;

    localparam int LATENCY = 5 * AXIS_BITS + 13;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [31:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [31:0] m_tdata;
    int fail_count;
    int pending_count;
    longint cycle_count;
    bit hold_output;

    radial_dead_zone_stick_filter uut (.*);

    rdz_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // output side stalls, with a long hold-off when requested
    initial
    begin
        m_tready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_output)
            begin
                m_tready <= 0;
                repeat (300) @(negedge clk);
                hold_output = 0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                int g;
                g = gap_len();
                if (g > 0)
                begin
                    m_tready <= 0;
                    repeat (g) @(negedge clk);
                end
            end
            m_tready <= 1;
        end
    end

    task automatic send_sample(input logic [15:0] x, input logic [15:0] y, input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            s_tvalid <= 0;
            repeat (g) @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {y, x};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] v);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 0;
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pending_count != 0) @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    function automatic logic [15:0] rand_axis();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return 16'($urandom_range(0, 6)) - 16'd3;
        if (p == 1) return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
        if (p < 5) return 16'($signed(16'($urandom_range(0, 12000))) - 16'sd6000);
        return 16'($urandom);
    endfunction

    initial
    begin
        logic [14:0] radius_set[6];
        logic [14:0] width_set[6];
        rst_n = 0;
        cfg_we = 0;
        cfg_index = REG_DEAD_ZONE_RADIUS;
        cfg_data = 0;
        s_tvalid = 0;
        s_tdata = 0;
        hold_output = 0;
        radius_set = '{15'd4915, 15'd0, 15'd32767, 15'd1, 15'd10000, 15'($urandom)};
        width_set = '{15'd1638, 15'd500, 15'd32767, 15'd0, 15'd20000, 15'($urandom)};
        repeat (12) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: extremes, near-zero band, axis-only, diagonal
        send_sample(16'h0000, 16'h0000, 0);
        send_sample(16'h0003, 16'hfffd, 0);
        send_sample(16'h0004, 16'h0000, 0);
        send_sample(16'h7fff, 16'h7fff, 0);
        send_sample(16'h8000, 16'h8000, 0);
        send_sample(16'h8000, 16'h7fff, 0);
        send_sample(16'h7fff, 16'h0000, 0);
        send_sample(16'h8000, 16'h0000, 0);
        send_sample(16'h0000, 16'h8000, 0);
        send_sample(16'h1000, 16'h0100, 0);
        send_sample(16'h0300, 16'h1800, 0);
        send_sample(16'h1400, 16'h0000, 0);
        send_sample(16'hec00, 16'h1400, 0);
        send_sample(16'h5555, 16'haaaa, 0);

        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            if (ph > 0)
            begin
                write_reg(REG_DEAD_ZONE_RADIUS, radius_set[ph]);
                write_reg(REG_CARDINAL_HALF_WIDTH, width_set[ph]);
            end
            send_sample(16'h7fff, 16'h8000, 0);
            send_sample(16'h0002, 16'h0001, 0);
            if (ph == 2) hold_output = 1;
            for (int i = 0; i < 240; i++)
                send_sample(rand_axis(), rand_axis(), ph != 2 || i > 120);
        end
        drain();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/rdz_pkg.sv
hw/rtl/rdz_isqrt.sv
hw/rtl/rdz_div.sv
hw/rtl/rdz_queue.sv
hw/rtl/rdz_front.sv
hw/rtl/rdz_back.sv
hw/rtl/radial_dead_zone_stick_filter.sv
bench/rdz_checker.sv
bench/tb_top.sv
